### hdl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, constants and functions of the seven-segment scan driver.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam int NUM_DIGITS_DEF = 4;
	localparam int SEGMENT_BITS   = 8;
	localparam logic [7:0] POINT_BIT = 8'h80;
	// x / 10 == (x * 0xCCCD) >> 19 for every 16-bit x
	localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
	localparam int DIV10_SHIFT = 19;

	typedef struct packed {
		logic [13:0] value;
		logic [1:0]  dot_position;
	} item_t;

	typedef struct packed {
		logic       serial_bit;
		logic [1:0] digit_index;
		logic       digit_done;
		logic [3:0] digit_select;
		logic       last;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic emit;
	} ssd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic conv_last;
		logic emit_last;
		logic out_space;
	} ssd_stat_t;

	// largest value shown on n digits (capped at five digits)
	function automatic int max_display(input int n);
		int m;
		m = 1;
		for (int i = 0; i < n && m < 100000; i++) begin
			m = m * 10;
		end
		return m - 1;
	endfunction

	// common-cathode pattern, bit 0 = segment a
	function automatic logic [7:0] seg_of(input logic [3:0] digit);
		logic [7:0] p;
		case (digit)
			4'd0: p = 8'h3F;
			4'd1: p = 8'h06;
			4'd2: p = 8'h5B;
			4'd3: p = 8'h4F;
			4'd4: p = 8'h66;
			4'd5: p = 8'h6D;
			4'd6: p = 8'h7D;
			4'd7: p = 8'h07;
			4'd8: p = 8'h7F;
			4'd9: p = 8'h6F;
			default: p = 8'h00;
		endcase
		return p;
	endfunction

endpackage

### hdl/ssd_ctrl.sv
// ----------------------------------------------------------------------------
// ssd_ctrl
// Sequencer: load an item, convert its digits, then shift out the bits.
// ----------------------------------------------------------------------------
module ssd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ssd_pkg::ssd_stat_t stat,
	output ssd_pkg::ssd_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CONV  = 3'b010,
		ST_SHIFT = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.conv_step = 1'b0;
		cmd.emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_last) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				cmd.emit = stat.out_space;
				if (stat.out_space && stat.emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign item_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### hdl/ssd_datapath.sv
// ----------------------------------------------------------------------------
// ssd_datapath
// Digit split by reciprocal divide-by-ten, pattern store, serializer and
// output register.
// ----------------------------------------------------------------------------
module ssd_datapath #(
	parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssd_pkg::item_t     item,
	input  ssd_pkg::ssd_cmd_t  cmd,
	output ssd_pkg::ssd_stat_t stat,
	output logic               result_valid,
	input  logic               result_ready,
	output ssd_pkg::result_t   result
);

	localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam logic [16:0] LIM = 17'(ssd_pkg::max_display(NUM_DIGITS));
	localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(NUM_DIGITS - 1);
	localparam logic [3:0] NUM_DIG4 = 4'(NUM_DIGITS);
	localparam logic [2:0] LAST_BIT = 3'(ssd_pkg::SEGMENT_BITS - 1);

	logic [7:0] pattern_q [NUM_DIGITS];

	logic [13:0]      val_q;
	logic [DIG_W-1:0] conv_idx_q;
	logic             point_en_q;
	logic [3:0]       point_sel_q;
	logic [DIG_W-1:0] digit_q;
	logic [2:0]       bit_q;
	logic [7:0]       shift_q;
	logic             out_valid_q;
	ssd_pkg::result_t out_q;

	// divide by ten
	logic [29:0] prod;
	logic [10:0] quot;
	logic [13:0] quot10;
	logic [13:0] rem14;
	logic [7:0]  seg;

	assign prod   = 30'(val_q) * 30'(ssd_pkg::DIV10_RECIP);
	assign quot   = prod[29:ssd_pkg::DIV10_SHIFT];
	assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem14  = val_q - quot10;
	assign seg    = ssd_pkg::seg_of(rem14[3:0])
		| ((point_en_q && (4'(conv_idx_q) == point_sel_q)) ? ssd_pkg::POINT_BIT : 8'h00);

	// serializer
	logic [7:0]  cur_pat;
	logic        bit_out;
	logic [7:0]  dig8;
	logic [7:0]  sel8;
	logic        done;
	logic [3:0]  dots4;

	assign cur_pat = pattern_q[digit_q];
	assign bit_out = (bit_q == 3'd0) ? cur_pat[7] : shift_q[7];
	assign dig8    = 8'(digit_q);
	assign sel8    = 8'b1 << dig8[2:0];
	assign done    = (bit_q == LAST_BIT);
	assign dots4   = {2'b00, item.dot_position};

	assign stat.conv_last = (conv_idx_q == '0);
	assign stat.emit_last = done && (digit_q == LAST_DIG);
	assign stat.out_space = !out_valid_q || result_ready;

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// pattern store: no reset, written before every read
	always_ff @(posedge clk) begin
		if (cmd.conv_step) begin
			pattern_q[conv_idx_q] <= seg;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q       <= ({3'b000, item.value} > LIM) ? LIM[13:0] : item.value;
			point_en_q  <= (item.dot_position != 2'd0) && (dots4 < NUM_DIG4);
			point_sel_q <= 4'(NUM_DIGITS - 1) - dots4;
		end else if (cmd.conv_step) begin
			val_q <= {3'b000, quot};
		end
		if (cmd.emit) begin
			shift_q <= (bit_q == 3'd0) ? {cur_pat[6:0], 1'b0} : {shift_q[6:0], 1'b0};
			out_q.serial_bit   <= bit_out;
			out_q.digit_index  <= dig8[1:0];
			out_q.digit_done   <= done;
			out_q.digit_select <= done ? sel8[3:0] : 4'd0;
			out_q.last         <= done && (digit_q == LAST_DIG);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_idx_q  <= '0;
			digit_q     <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				conv_idx_q <= LAST_DIG;
			end else if (cmd.conv_step && (conv_idx_q != '0)) begin
				conv_idx_q <= conv_idx_q - 1'b1;
			end
			if (cmd.emit) begin
				bit_q <= bit_q + 3'd1;
				if (done) begin
					digit_q <= (digit_q == LAST_DIG) ? '0 : digit_q + 1'b1;
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hdl/seven_segment_scan_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver
// Multiplexed seven-segment display driver feeding a serial shift register.
// ----------------------------------------------------------------------------
// Usage:
//   The item channel (item_valid/item_ready/item) takes one word per display
//   update: a value already scaled by 10^dot_position and the point position.
//   Values above the display range show all nines. A point position of 0 or
//   one not inside the display sets no point bit.
//   The result channel (result_valid/result_ready/result) gives
//   NUM_DIGITS*8 words per item: segment bits MSB first, thousands digit
//   first. digit_done marks each digit's eighth bit and carries the one-hot
//   digit_select; last marks the final word.
// Timing:
//   One item at a time. After acceptance an item's value is split one digit
//   per cycle through the shared divide-by-ten unit, then its bits are
//   shifted out one bit per cycle while the receiver does not stall.
//   item_ready rises again as the final word enters the output register, so
//   the next item is accepted only after the previous one is fully shifted.
// Reset and stall:
//   arst_n clears the sequencer, counters and output valid; the pattern store
//   is rewritten by every item and needs no reset. When the receiver stalls,
//   hold the output word and freeze the shift sequence.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver #(
	parameter int NUM_DIGITS = ssd_pkg::NUM_DIGITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  ssd_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output ssd_pkg::result_t result
);

	// command and status between sequencer and datapath
	ssd_pkg::ssd_cmd_t  cmd;
	ssd_pkg::ssd_stat_t stat;

	// sequencer: idle, convert digits, shift bits
	ssd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: divide-by-ten, pattern store, serializer, output register
	ssd_datapath #(
		.NUM_DIGITS (NUM_DIGITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

### sim/seven_segment_scan_driver_tb.sv
// ----------------------------------------------------------------------------
// seven_segment_scan_driver_tb
// Self-checking bench for the four-digit scan driver. Feed display words
// (value, point position) over the item channel. An in-bench predictor splits
// each value into decimal digits, applies the segment table and the point bit,
// and queues the 32 serial words it must cause. Each returned word is compared
// field by field against the oldest queued word. Run a directed set of edge
// values, then random words under several sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module seven_segment_scan_driver_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_DIGITS     = 4;
	localparam int WORDS_PER_ITEM = NUM_DIGITS * ssd_pkg::SEGMENT_BITS;
	localparam int MAX_SHOWN      = 9999;
	localparam int CYCLE_LIMIT    = 300000;
	localparam int SETTLE_CYCLES  = 40;

	// common-cathode patterns, bit 0 = segment a, bit 7 = point
	localparam logic [7:0] SEG_CODE [0:9] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	// directed words: zero, full range, overrange, every point position,
	// every digit value, bit patterns around the 14-bit boundaries
	localparam int N_DIRECTED = 18;
	localparam int DIR_VALUE [N_DIRECTED] = '{
		0, 9999, 10000, 16383, 1234, 1234, 1234, 1234, 5678,
		9090, 8001, 7, 10, 8191, 8192, 4567, 9999, 10001
	};
	localparam int DIR_POINT [N_DIRECTED] = '{
		0, 0, 1, 3, 0, 1, 2, 3, 2,
		1, 3, 0, 3, 2, 1, 0, 3, 2
	};

	// ------------------------------------------------------------------------
	// Scoreboard: predict the serial stream of each accepted display word and
	// check returned words against it in order.
	// ------------------------------------------------------------------------
	class scan_scoreboard;
		ssd_pkg::result_t pending_words[$];
		int      errors;
		int      words_seen;

		function new();
			errors     = 0;
			words_seen = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		// expand one display word into its serial stream
		function void note_item(ssd_pkg::item_t it);
			logic [7:0] digit_pat [NUM_DIGITS];
			int         rest;
			int         k;
			ssd_pkg::result_t w;
			rest = (int'(it.value) > MAX_SHOWN) ? MAX_SHOWN : int'(it.value);
			// split thousands..units, units land in the last slot
			for (int d = NUM_DIGITS - 1; d >= 0; d--) begin
				digit_pat[d] = SEG_CODE[rest % 10];
				rest = rest / 10;
			end
			// mark the digit just before the implied point
			if (it.dot_position != 2'd0 && int'(it.dot_position) < NUM_DIGITS) begin
				digit_pat[NUM_DIGITS - 1 - int'(it.dot_position)][7] = 1'b1;
			end
			k = 0;
			for (int d = 0; d < NUM_DIGITS; d++) begin
				for (int b = 0; b < ssd_pkg::SEGMENT_BITS; b++) begin
					w.serial_bit   = digit_pat[d][ssd_pkg::SEGMENT_BITS - 1 - b];
					w.digit_index  = d[1:0];
					w.digit_done   = (b == ssd_pkg::SEGMENT_BITS - 1);
					w.digit_select = w.digit_done ? (4'b0001 << d) : 4'b0000;
					w.last         = (k == WORDS_PER_ITEM - 1);
					pending_words.push_back(w);
					k++;
				end
			end
		endfunction

		task check_word(ssd_pkg::result_t got);
			ssd_pkg::result_t want;
			words_seen++;
			if (pending_words.size() == 0) begin
				report($sformatf("word %0d arrived with nothing expected (%h)",
					words_seen, got));
				return;
			end
			want = pending_words.pop_front();
			if (got.serial_bit !== want.serial_bit)
				report($sformatf("word %0d serial_bit %b, want %b",
					words_seen, got.serial_bit, want.serial_bit));
			if (got.digit_index !== want.digit_index)
				report($sformatf("word %0d digit_index %0d, want %0d",
					words_seen, got.digit_index, want.digit_index));
			if (got.digit_done !== want.digit_done)
				report($sformatf("word %0d digit_done %b, want %b",
					words_seen, got.digit_done, want.digit_done));
			if (got.digit_select !== want.digit_select)
				report($sformatf("word %0d digit_select %b, want %b",
					words_seen, got.digit_select, want.digit_select));
			if (got.last !== want.last)
				report($sformatf("word %0d last %b, want %b",
					words_seen, got.last, want.last));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	ssd_pkg::item_t   item;
	logic    result_valid;
	logic    result_ready;
	ssd_pkg::result_t result;

	int      send_idle_pct;
	int      recv_stall_pct;
	int      cycles;

	scan_scoreboard sb = new();

	seven_segment_scan_driver #(
		.NUM_DIGITS(NUM_DIGITS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d words still expected",
					cycles, sb.pending_words.size());
				$display("seven_segment_scan_driver_tb NOT OK");
				$finish;
			end
		end
	end

	// Receiver: redraw ready on every falling edge so stalls hit every bit and
	// digit boundary of the shift sequence.
	initial begin
		forever begin
			@(negedge clk);
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Sample the result channel at the rising edge.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			sb.check_word(result);
	end

	// ------------------------------------------------------------------------
	// Driving tasks
	// ------------------------------------------------------------------------

	// Offer one display word; hold valid and payload until accepted.
	task send_item(ssd_pkg::item_t it);
		@(negedge clk);
		// idle the sender for a random number of cycles first
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (!item_ready);
		sb.note_item(it);
	endtask

	// Drop valid and hold off until every expected word has come back.
	task drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (sb.pending_words.size() != 0)
			@(posedge clk);
	endtask

	// One random phase under a given idling mix.
	task run_phase(int idle_pct, int stall_pct, int count);
		ssd_pkg::item_t it;
		int    pick;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			// mostly in-range values, some overrange, some near the edges
			if (pick < 70)
				it.value = 14'($urandom_range(MAX_SHOWN));
			else if (pick < 85)
				it.value = 14'($urandom_range(16383, MAX_SHOWN + 1));
			else if (pick < 93)
				it.value = 14'($urandom_range(MAX_SHOWN + 20, MAX_SHOWN - 20));
			else
				it.value = 14'($urandom_range(20));
			it.dot_position = 2'($urandom_range(3));
			send_item(it);
		end
		drain();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		ssd_pkg::item_t it;
		arst_n         = 1'b0;
		item_valid     = 1'b0;
		item           = '0;
		result_ready   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;

		// hold reset, then release it on a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed edges, back to back
		for (int i = 0; i < N_DIRECTED; i++) begin
			it.value        = 14'(DIR_VALUE[i]);
			it.dot_position = 2'(DIR_POINT[i]);
			send_item(it);
		end
		// pause the sender until the directed stream has fully returned
		drain();

		run_phase(0, 0, 60);
		run_phase(60, 0, 64);
		run_phase(0, 60, 64);
		run_phase(10, 10, 64);

		// let any stray trailing word show up before the verdict
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_words.size() != 0)
			sb.report($sformatf("%0d words never arrived", sb.pending_words.size()));

		if (sb.errors == 0) begin
			$display("seven_segment_scan_driver_tb OK");
		end else begin
			$display("seven_segment_scan_driver_tb NOT OK");
		end
		$finish;
	end

endmodule
